// ----- design/ba_pkg.sv -----
`timescale 1ns / 1ps

package ba_pkg;

    localparam int MIN_BLOCK_DEF    = 32;
    localparam int LEVELS_DEF       = 12;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int CODE_W = 4;
    localparam int OFF_W  = 16;
    localparam int REQ_W  = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic              start;
        logic              free;
        logic [CODE_W-1:0] lvl;
    } t_unit;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_POP,
        S_A_SPLIT,
        S_F_CHK,
        S_F_BRD,
        S_F_BCHK,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_F_HI,
        S_F_LO,
        S_RESP
    } t_state;

endpackage

// ----- design/buddy_allocator.sv -----
`timescale 1ns / 1ps
// Binary buddy allocator.
// Input channel (i_valid/o_ready): one item per request, i_opcode selects
// allocate (i_request_bytes) or free (i_block_offset). Output channel
// (o_valid/i_ready): exactly one item per request with offset, level, status.
// Unit headers live in one single-port RAM of 2**(LEVELS-1) words, the free
// stacks in a second RAM of 2**LEVELS words; both have registered reads.
// One request is in work at a time; its result appears in the same cycle in
// which the next item can be taken. A request rejected at once goes straight
// to the response state; an allocate pops a free stack, then splits (one split
// per cycle) until the block fits; a free checks the unit header and may read
// the buddy, and each merge scans the buddy's free stack and shifts its entries
// through the stack RAM port while the buddy is removed.
// Reset, and every write of pool_size_code, starts a clearing pass over the
// 2**(LEVELS-1) words of the unit RAM (2048 by default), during which o_ready is
// low; the APB port stays usable. A finished result waits in a staging
// register while the output register is stalled; the block then holds in its
// response state until the output register frees.
module buddy_allocator #(
    parameter int MIN_BLOCK    = ba_pkg::MIN_BLOCK_DEF,
    parameter int LEVELS       = ba_pkg::LEVELS_DEF,
    parameter int HEADER_BYTES = ba_pkg::HEADER_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_opcode,
    input  logic [ba_pkg::REQ_W-1:0] i_request_bytes,
    input  logic [ba_pkg::OFF_W-1:0] i_block_offset,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ba_pkg::OFF_W-1:0] o_result_offset,
    output logic [ba_pkg::CODE_W-1:0] o_size_level,
    output logic                     o_status,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import ba_pkg::*;

    localparam int UNITS  = 1 << (LEVELS - 1);
    localparam int UNIT_W = LEVELS - 1;
    localparam int SADR_W = LEVELS;
    localparam int CNT_W  = LEVELS;
    localparam int MB_SH  = $clog2(MIN_BLOCK);
    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(LEVELS - 1);
    localparam logic [CODE_W-1:0] CODE_RST = (LEVELS - 1 < 11) ? CODE_W'(LEVELS - 1)
                                                             : CODE_W'(11);

    function automatic logic fits(input logic [CODE_W-1:0] lv, input logic [REQ_W-1:0] req);
        int usable;
        usable = (MIN_BLOCK << lv) - HEADER_BYTES;
        return usable >= int'({16'b0, req});
    endfunction

    function automatic logic [SADR_W-1:0] st_addr(input logic [CODE_W-1:0] lv,
                                                   input logic [CNT_W-1:0] idx);
        return SADR_W'((1 << LEVELS) - ((1 << LEVELS) >> lv) + int'(idx));
    endfunction

    function automatic logic [CNT_W-1:0] cap(input logic [CODE_W-1:0] lv);
        return CNT_W'(UNITS >> lv);
    endfunction

    t_unit            r_umem [UNITS];
    logic [UNIT_W-1:0] r_smem [1 << LEVELS];

    t_unit             r_urd;
    logic [UNIT_W-1:0] r_srd;

    logic              u_we, u_re, s_we, s_re;
    logic [UNIT_W-1:0] u_waddr, u_raddr;
    t_unit             u_wdata;
    logic [SADR_W-1:0] s_waddr, s_raddr;
    logic [UNIT_W-1:0] s_wdata;

    t_state            r_state, n_state;
    logic [CODE_W-1:0] r_code;
    logic [CNT_W-1:0]  r_cnt [LEVELS];
    logic [UNIT_W-1:0] r_clr_idx, n_clr_idx;
    logic [UNIT_W-1:0] r_u, n_u;
    logic [CODE_W-1:0] r_lv, n_lv;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic [CODE_W-1:0] r_res_lvl, n_res_lvl;
    logic              r_res_st, n_res_st;
    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_off;
    logic [CODE_W-1:0] r_out_lvl;
    logic              r_out_st;

    logic              cnt_inc, cnt_dec;
    logic [CODE_W-1:0] cnt_lv;

    logic              w_acc, w_found, w_off_bad, w_fchk_ok, w_merge, w_split;
    logic              w_lt, w_hit, w_slot, w_clr_last, w_cfg_wr, w_more;
    logic [CODE_W-1:0] w_found_lv;
    logic [31:0]       w_off_u;
    logic [UNIT_W-1:0] w_b, w_hi, w_lo, w_twin;
    logic [CNT_W-1:0]  w_n;
    logic [CODE_W-1:0] w_cfg_code;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {28'b0, r_code} : 32'b0;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign w_cfg_code = (pwdata[3:0] > CODE_MAX) ? CODE_MAX : pwdata[3:0];

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_result_offset = r_out_off;
    assign o_size_level    = r_out_lvl;
    assign o_status        = r_out_st;

    assign w_acc      = i_valid && o_ready;
    assign w_slot     = !r_out_valid || i_ready;
    assign w_clr_last = (r_clr_idx == {UNIT_W{1'b1}});
    assign w_off_u    = 32'(i_block_offset) >> MB_SH;
    assign w_off_bad  = ((i_block_offset & OFF_W'(MIN_BLOCK - 1)) != '0) ||
                        (w_off_u >= (32'd1 << r_code));
    assign w_fchk_ok  = r_urd.start && !r_urd.free && (r_urd.lvl <= r_code);
    assign w_b        = r_u ^ UNIT_W'(1 << r_lv);
    assign w_hi       = (r_u > w_b) ? r_u : w_b;
    assign w_lo       = (r_u > w_b) ? w_b : r_u;
    assign w_merge    = r_urd.start && r_urd.free && (r_urd.lvl == r_lv);
    assign w_split    = (r_lv != '0) && fits(r_lv - 1'b1, r_req);
    assign w_twin     = r_u + UNIT_W'(1 << (r_lv - 1'b1));
    assign w_n        = r_cnt[r_lv];
    assign w_lt       = r_idx < w_n;
    assign w_hit      = (r_srd == w_b);
    assign w_more     = ({1'b0, r_lv} + 5'd1) < {1'b0, r_code};

    always_comb begin
        w_found    = 1'b0;
        w_found_lv = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (!w_found && CODE_W'(l) <= r_code && fits(CODE_W'(l), i_request_bytes) &&
                r_cnt[l] != '0) begin
                w_found    = 1'b1;
                w_found_lv = CODE_W'(l);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (w_clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (w_acc) begin
                    if (i_opcode == OP_ALLOC) n_state = w_found ? S_A_POP : S_RESP;
                    else                      n_state = w_off_bad ? S_RESP : S_F_CHK;
                end
            end
            S_A_POP:   n_state = S_A_SPLIT;
            S_A_SPLIT: if (!w_split) n_state = S_RESP;
            S_F_CHK:   n_state = (w_fchk_ok && r_urd.lvl < r_code) ? S_F_BRD : S_RESP;
            S_F_BRD:   n_state = S_F_BCHK;
            S_F_BCHK:  n_state = w_merge ? S_RM_RD : S_RESP;
            S_RM_RD:   n_state = w_lt ? S_RM_CMP : S_F_HI;
            S_RM_CMP:  n_state = w_hit ? S_SH_RD : S_RM_RD;
            S_SH_RD:   n_state = w_lt ? S_SH_WR : S_F_HI;
            S_SH_WR:   n_state = S_SH_RD;
            S_F_HI:    n_state = S_F_LO;
            S_F_LO:    n_state = w_more ? S_F_BRD : S_RESP;
            S_RESP:    if (w_slot) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        if (w_cfg_wr) n_state = S_CLEAR;
    end

    always_comb begin
        n_clr_idx = r_clr_idx;
        n_u       = r_u;
        n_lv      = r_lv;
        n_req     = r_req;
        n_idx     = r_idx;
        n_res_off = r_res_off;
        n_res_lvl = r_res_lvl;
        n_res_st  = r_res_st;
        u_we = 1'b0; u_waddr = r_u; u_wdata = '0;
        u_re = 1'b0; u_raddr = r_u;
        s_we = 1'b0; s_waddr = '0;  s_wdata = r_u;
        s_re = 1'b0; s_raddr = '0;
        cnt_inc = 1'b0; cnt_dec = 1'b0; cnt_lv = r_lv;
        case (r_state)
            S_CLEAR: begin
                u_we      = 1'b1;
                u_waddr   = r_clr_idx;
                u_wdata   = (r_clr_idx == '0) ? t_unit'{1'b1, 1'b1, r_code} : '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (w_clr_last) begin
                    s_we    = 1'b1;
                    s_waddr = st_addr(r_code, '0);
                    s_wdata = '0;
                end
            end
            S_IDLE: begin
                n_res_off = '0;
                n_res_lvl = '0;
                n_res_st  = ST_FAIL;
                n_req     = i_request_bytes;
                n_u       = w_off_u[UNIT_W-1:0];
                if (w_acc) begin
                    if (i_opcode == OP_ALLOC) begin
                        if (w_found) begin
                            n_lv    = w_found_lv;
                            s_re    = 1'b1;
                            s_raddr = st_addr(w_found_lv, r_cnt[w_found_lv] - 1'b1);
                            cnt_dec = 1'b1;
                            cnt_lv  = w_found_lv;
                        end
                    end else if (!w_off_bad) begin
                        u_re    = 1'b1;
                        u_raddr = w_off_u[UNIT_W-1:0];
                    end
                end
            end
            S_A_POP: n_u = r_srd;
            S_A_SPLIT: begin
                u_we    = 1'b1;
                u_waddr = r_u;
                if (w_split) begin
                    u_wdata = t_unit'{1'b1, 1'b1, r_lv - 1'b1};
                    cnt_lv  = r_lv - 1'b1;
                    s_we    = r_cnt[r_lv - 1'b1] < cap(r_lv - 1'b1);
                    cnt_inc = s_we;
                    s_waddr = st_addr(r_lv - 1'b1, r_cnt[r_lv - 1'b1]);
                    s_wdata = r_u;
                    n_u     = w_twin;
                    n_lv    = r_lv - 1'b1;
                end else begin
                    u_wdata   = t_unit'{1'b1, 1'b0, r_lv};
                    n_res_off = OFF_W'(32'(r_u) << MB_SH);
                    n_res_lvl = r_lv;
                    n_res_st  = ST_OK;
                end
            end
            S_F_CHK: begin
                if (w_fchk_ok) begin
                    n_res_st = ST_OK;
                    n_lv     = r_urd.lvl;
                    u_we     = 1'b1;
                    u_waddr  = r_u;
                    u_wdata  = t_unit'{1'b1, 1'b1, r_urd.lvl};
                    cnt_lv   = r_urd.lvl;
                    s_we     = r_cnt[r_urd.lvl] < cap(r_urd.lvl);
                    cnt_inc  = s_we;
                    s_waddr  = st_addr(r_urd.lvl, r_cnt[r_urd.lvl]);
                    s_wdata  = r_u;
                end
            end
            S_F_BRD: begin
                u_re    = 1'b1;
                u_raddr = w_b;
            end
            S_F_BCHK: begin
                if (w_merge) begin
                    cnt_dec = 1'b1;
                    n_idx   = '0;
                end
            end
            S_RM_RD: begin
                s_re    = w_lt;
                s_raddr = st_addr(r_lv, r_idx);
            end
            S_RM_CMP: n_idx = r_idx + 1'b1;
            S_SH_RD: begin
                s_re    = w_lt;
                s_raddr = st_addr(r_lv, r_idx);
                cnt_dec = !w_lt;
            end
            S_SH_WR: begin
                s_we    = 1'b1;
                s_waddr = st_addr(r_lv, r_idx - 1'b1);
                s_wdata = r_srd;
                n_idx   = r_idx + 1'b1;
            end
            S_F_HI: begin
                u_we    = 1'b1;
                u_waddr = w_hi;
                u_wdata = '0;
            end
            S_F_LO: begin
                u_we    = 1'b1;
                u_waddr = w_lo;
                u_wdata = t_unit'{1'b1, 1'b1, r_lv + 1'b1};
                cnt_lv  = r_lv + 1'b1;
                s_we    = r_cnt[r_lv + 1'b1] < cap(r_lv + 1'b1);
                cnt_inc = s_we;
                s_waddr = st_addr(r_lv + 1'b1, r_cnt[r_lv + 1'b1]);
                s_wdata = w_lo;
                n_u     = w_lo;
                n_lv    = r_lv + 1'b1;
            end
            S_RESP: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (u_we) r_umem[u_waddr] <= u_wdata;
        if (u_re) r_urd <= r_umem[u_raddr];
        if (s_we) r_smem[s_waddr] <= s_wdata;
        if (s_re) r_srd <= r_smem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_lv      <= n_lv;
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_res_off <= n_res_off;
        r_res_lvl <= n_res_lvl;
        r_res_st  <= n_res_st;
        if (r_state == S_RESP && w_slot) begin
            r_out_off <= r_res_off;
            r_out_lvl <= r_res_lvl;
            r_out_st  <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= CODE_RST;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= (CODE_W'(l) == CODE_RST) ? CNT_W'(1) : '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_RESP && w_slot) r_out_valid <= 1'b1;
            else if (i_ready)                r_out_valid <= 1'b0;
            if (w_cfg_wr) begin
                r_code    <= w_cfg_code;
                r_clr_idx <= '0;
                for (int l = 0; l < LEVELS; l++) begin
                    r_cnt[l] <= (CODE_W'(l) == w_cfg_code) ? CNT_W'(1) : '0;
                end
            end else begin
                r_clr_idx <= n_clr_idx;
                if (cnt_inc)      r_cnt[cnt_lv] <= r_cnt[cnt_lv] + 1'b1;
                else if (cnt_dec) r_cnt[cnt_lv] <= r_cnt[cnt_lv] - 1'b1;
            end
        end
    end

endmodule

// ----- design/ba_chk.sv -----
`timescale 1ns / 1ps
module ba_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [ba_pkg::OFF_W-1:0] o_result_offset,
    input logic [ba_pkg::CODE_W-1:0] o_size_level,
    input logic                     o_status
);
    import ba_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_ready)
        else $error("outputs active after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_offset) && $stable(o_status))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FAIL |-> o_result_offset == '0 && o_size_level == '0)
        else $error("failed result carries data");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |->
        (32'(o_result_offset) & ((32'(MIN_BLOCK_DEF) << o_size_level) - 32'd1)) == 32'd0)
        else $error("granted block misaligned");

endmodule

bind buddy_allocator ba_chk u_ba_chk (.*);
